/* hw/rtl/ramped_pi_speed_regulator_defines.svh */
// ----------------------------------------------------------------------------
// ramped pi speed regulator assertion macros
// property wrappers used by the regulator tracker rtl
// ----------------------------------------------------------------------------
`ifndef RAMPED_PI_SPEED_REGULATOR_DEFINES_SVH
`define RAMPED_PI_SPEED_REGULATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition holds on every clock edge out of reset
`define RPSR_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rpsr assertion failed");

// antecedent implies consequent in the following cycle
`define RPSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpsr assertion failed");

`else

`define RPSR_ASSERT_ALWAYS(label, clk, rst, cond)
`define RPSR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/rpsr_pkg.sv */
// ----------------------------------------------------------------------------
// rpsr package
// types and constants shared by the ramped pi speed regulator
// ----------------------------------------------------------------------------
package rpsr_pkg;

  // gain registers are q8.8
  localparam int GAIN_FRAC_BITS = 8;

  // ramp setpoint never exceeds the magnitude of the most negative target
  localparam logic [15:0] RAMP_MAX = 16'h8000;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PROP_GAIN        = 3'd0,
    REG_INTEG_GAIN       = 3'd1,
    REG_ACCEL_STEP       = 3'd2,
    REG_STANDSTILL_WIDTH = 3'd3,
    REG_FORWARD_LIMIT    = 3'd4,
    REG_BACKWARD_LIMIT   = 3'd5,
    REG_INVERT_DIRECTION = 3'd6
  } cfg_reg_t;

  // register reset values
  localparam logic [15:0] PROP_GAIN_RST        = 16'd3840;
  localparam logic [15:0] INTEG_GAIN_RST       = 16'd128;
  localparam logic [14:0] ACCEL_STEP_RST       = 15'd128;
  localparam logic [11:0] STANDSTILL_WIDTH_RST = 12'd1500;
  localparam logic [11:0] FORWARD_LIMIT_RST    = 12'd2000;
  localparam logic [11:0] BACKWARD_LIMIT_RST   = 12'd1000;

  // configuration register file contents
  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [14:0] accel_step;
    logic [11:0] standstill_width;
    logic [11:0] forward_limit;
    logic [11:0] backward_limit;
    logic        invert_direction;
  } cfg_t;

  // per-item control flags carried down the pipeline
  typedef struct packed {
    logic neg;
    logic stop;
  } flags_t;

endpackage

/* hw/rtl/rpsr_track.sv */
// ----------------------------------------------------------------------------
// rpsr setpoint tracker
// ramps the setpoint, forms the speed error and updates the saturating sum
// ----------------------------------------------------------------------------
`include "ramped_pi_speed_regulator_defines.svh"

module rpsr_track #(
  parameter int INTEG_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rpsr_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            target_speed,
  input  logic        [14:0]            measured_speed,
  output logic                          trk_valid,
  input  logic                          trk_ready,
  output logic signed [16:0]            trk_err,
  output logic signed [INTEG_WIDTH-1:0] trk_sum,
  output rpsr_pkg::flags_t              trk_flags
);
  import rpsr_pkg::*;

  localparam int SUM_W = INTEG_WIDTH + 1;

  logic [15:0]                   ramp_setpoint;
  logic [15:0]                   ramp_setpoint_next;
  logic signed [INTEG_WIDTH-1:0] error_sum;
  logic signed [INTEG_WIDTH-1:0] error_sum_next;

  logic                  accept;
  logic                  stage_free;
  logic signed [16:0]    tgt_ext;
  logic signed [16:0]    tgt;
  logic                  tgt_zero;
  logic                  tgt_neg;
  logic [15:0]           mag;
  logic signed [17:0]    diff;
  logic signed [17:0]    step;
  logic signed [17:0]    diff_lim;
  logic [17:0]           ramp_sum;
  logic signed [16:0]    err;
  logic signed [SUM_W-1:0] sum_wide;

  // output stage frees when empty or being drained
  assign stage_free = !trk_valid || trk_ready;
  assign in_ready   = stage_free;
  assign accept     = in_valid && in_ready;

  // direction and magnitude of the target
  always_comb begin
    tgt_ext  = {target_speed[15], target_speed};
    tgt      = cfg.invert_direction ? -tgt_ext : tgt_ext;
    tgt_zero = (target_speed == 16'sd0);
    tgt_neg  = tgt[16];
    mag      = tgt_neg ? 16'(-tgt) : tgt[15:0];
  end

  // ramp toward the magnitude by at most the acceleration step
  always_comb begin
    diff = $signed({2'b00, mag}) - $signed({2'b00, ramp_setpoint});
    step = $signed({3'b000, cfg.accel_step});
    if (diff < -step) begin
      diff_lim = -step;
    end else if (diff > step) begin
      diff_lim = step;
    end else begin
      diff_lim = diff;
    end
    ramp_sum = 18'($signed({2'b00, ramp_setpoint}) + diff_lim);
  end

  // speed error and saturating error sum
  always_comb begin
    err      = $signed({1'b0, ramp_sum[15:0]}) - $signed({2'b00, measured_speed});
    sum_wide = $signed({error_sum[INTEG_WIDTH-1], error_sum})
             + $signed({{(SUM_W-17){err[16]}}, err});
    if (sum_wide[SUM_W-1] != sum_wide[SUM_W-2]) begin
      error_sum_next = sum_wide[SUM_W-1] ? {1'b1, {(INTEG_WIDTH-1){1'b0}}}
                                         : {1'b0, {(INTEG_WIDTH-1){1'b1}}};
    end else begin
      error_sum_next = sum_wide[INTEG_WIDTH-1:0];
    end
    ramp_setpoint_next = ramp_sum[15:0];
    if (tgt_zero) begin
      ramp_setpoint_next = '0;
      error_sum_next     = '0;
    end
  end

  // regulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_setpoint <= '0;
      error_sum     <= '0;
    end else if (accept) begin
      ramp_setpoint <= ramp_setpoint_next;
      error_sum     <= error_sum_next;
    end
  end

  // tracker output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      trk_valid <= 1'b0;
    end else if (stage_free) begin
      trk_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      trk_err        <= err;
      trk_sum        <= error_sum_next;
      trk_flags.neg  <= tgt_neg;
      trk_flags.stop <= tgt_zero;
    end
  end

  `RPSR_ASSERT_ALWAYS(a_ramp_bound, clk, rst, ramp_setpoint <= RAMP_MAX)
  `RPSR_ASSERT_NEXT(a_stop_clears, clk, rst, accept && tgt_zero,
                    ramp_setpoint == '0 && error_sum == '0)
  `RPSR_ASSERT_NEXT(a_state_holds, clk, rst, !accept,
                    $stable(ramp_setpoint) && $stable(error_sum))

endmodule

/* hw/rtl/rpsr_shape.sv */
// ----------------------------------------------------------------------------
// rpsr output shaper
// pi products, direction sign, standstill offset and limit clamp
// ----------------------------------------------------------------------------
module rpsr_shape #(
  parameter int SPEED_FRAC_BITS = 8,
  parameter int INTEG_WIDTH     = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rpsr_pkg::cfg_t                cfg,
  input  logic                          trk_valid,
  output logic                          trk_ready,
  input  logic signed [16:0]            trk_err,
  input  logic signed [INTEG_WIDTH-1:0] trk_sum,
  input  rpsr_pkg::flags_t              trk_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [11:0]                   pulse_width,
  output logic                          stopped
);
  import rpsr_pkg::*;

  localparam int OUT_FRAC_BITS = GAIN_FRAC_BITS + SPEED_FRAC_BITS;
  localparam int IPROD_W       = INTEG_WIDTH + 17;
  localparam int PI_W          = INTEG_WIDTH + 18;
  localparam int TOT_W         = INTEG_WIDTH + 20;

  // stage flags
  logic s2_valid;
  logic s3_valid;
  logic out_free;
  logic s3_free;
  logic s2_free;

  // stage payloads
  logic signed [32:0]        prod_p;
  logic signed [IPROD_W-1:0] prod_i;
  flags_t                    s2_flags;
  logic signed [PI_W-1:0]    pi_sum;
  flags_t                    s3_flags;

  logic signed [TOT_W-1:0] pi_ext;
  logic signed [TOT_W-1:0] std_sh;
  logic signed [TOT_W-1:0] lo_sh;
  logic signed [TOT_W-1:0] hi_sh;
  logic signed [TOT_W-1:0] total;
  logic [11:0]             pulse_calc;

  // each stage moves on when the one below has room
  assign out_free  = !out_valid || out_ready;
  assign s3_free   = !s3_valid || out_free;
  assign s2_free   = !s2_valid || s3_free;
  assign trk_ready = s2_free;

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_valid <= trk_valid;
      end
      if (s3_free) begin
        s3_valid <= s2_valid;
      end
      if (out_free) begin
        out_valid <= s3_valid;
      end
    end
  end

  // proportional and integral products
  always_ff @(posedge clk) begin
    if (s2_free && trk_valid) begin
      prod_p   <= $signed({1'b0, cfg.prop_gain}) * trk_err;
      prod_i   <= $signed({1'b0, cfg.integ_gain}) * trk_sum;
      s2_flags <= trk_flags;
    end
  end

  // pi sum
  always_ff @(posedge clk) begin
    if (s3_free && s2_valid) begin
      pi_sum   <= $signed({{(PI_W-33){prod_p[32]}}, prod_p})
                + $signed({{(PI_W-IPROD_W){prod_i[IPROD_W-1]}}, prod_i});
      s3_flags <= s2_flags;
    end
  end

  // signed offset from standstill and clamp to the limits; a stop gives the standstill width
  always_comb begin
    pi_ext = $signed({{(TOT_W-PI_W){pi_sum[PI_W-1]}}, pi_sum});
    std_sh = $signed({{(TOT_W-12){1'b0}}, cfg.standstill_width}) <<< OUT_FRAC_BITS;
    lo_sh  = $signed({{(TOT_W-12){1'b0}}, cfg.backward_limit}) <<< OUT_FRAC_BITS;
    hi_sh  = $signed({{(TOT_W-12){1'b0}}, cfg.forward_limit}) <<< OUT_FRAC_BITS;
    total  = s3_flags.neg ? (std_sh - pi_ext) : (std_sh + pi_ext);
    if (s3_flags.stop) begin
      pulse_calc = cfg.standstill_width;
    end else if (total < lo_sh) begin
      pulse_calc = cfg.backward_limit;
    end else if (total > hi_sh) begin
      pulse_calc = cfg.forward_limit;
    end else begin
      pulse_calc = total[OUT_FRAC_BITS +: 12];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_free && s3_valid) begin
      pulse_width <= pulse_calc;
      stopped     <= s3_flags.stop;
    end
  end

endmodule

/* hw/rtl/ramped_pi_speed_regulator.sv */
// ----------------------------------------------------------------------------
// ramped pi speed regulator
// pi speed loop with acceleration-limited setpoint, drives a pulse width
// ----------------------------------------------------------------------------
// Each input transaction (in_valid/in_ready) is one control period carrying
// the signed target speed and the measured speed magnitude. Each produces
// exactly one output transaction (out_valid/out_ready) with the clamped
// drive pulse width and the stopped flag; a zero target gives the
// standstill width and clears the ramp and the error sum.
// Registers are written over the cfg channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data); cfg_ready is always high and writes are to be
// made only while no transaction is in flight. Unknown indexes are ignored.
// Throughput is one transaction per cycle while out_ready stays high: the
// ramp and error-sum update is a recurrence closed within the tracker
// stage, and the products, pi sum and clamp are pipelined behind it. From
// input acceptance to out_valid lie the tracker register, which loads on
// acceptance, then the product, sum and result registers.
// Synchronous reset restores register defaults, zeroes the ramp and sum
// and empties the pipeline. When the receiver stalls, the result holds and
// earlier stages keep filling; in_ready drops once all four stages are full.
// ----------------------------------------------------------------------------
module ramped_pi_speed_regulator #(
  parameter int SPEED_FRAC_BITS = 8,
  parameter int INTEG_WIDTH     = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] target_speed,
  input  logic        [14:0] measured_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [11:0] pulse_width,
  output logic               stopped
);
  import rpsr_pkg::*;

  cfg_t                          cfg;
  logic                          trk_valid;
  logic                          trk_ready;
  logic signed [16:0]            trk_err;
  logic signed [INTEG_WIDTH-1:0] trk_sum;
  flags_t                        trk_flags;

  assign cfg_ready = 1'b1;

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain        <= PROP_GAIN_RST;
      cfg.integ_gain       <= INTEG_GAIN_RST;
      cfg.accel_step       <= ACCEL_STEP_RST;
      cfg.standstill_width <= STANDSTILL_WIDTH_RST;
      cfg.forward_limit    <= FORWARD_LIMIT_RST;
      cfg.backward_limit   <= BACKWARD_LIMIT_RST;
      cfg.invert_direction <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROP_GAIN:        cfg.prop_gain        <= cfg_data;
        REG_INTEG_GAIN:       cfg.integ_gain       <= cfg_data;
        REG_ACCEL_STEP:       cfg.accel_step       <= cfg_data[14:0];
        REG_STANDSTILL_WIDTH: cfg.standstill_width <= cfg_data[11:0];
        REG_FORWARD_LIMIT:    cfg.forward_limit    <= cfg_data[11:0];
        REG_BACKWARD_LIMIT:   cfg.backward_limit   <= cfg_data[11:0];
        REG_INVERT_DIRECTION: cfg.invert_direction <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // setpoint ramp and error sum
  rpsr_track #(
    .INTEG_WIDTH(INTEG_WIDTH)
  ) u_track (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .target_speed  (target_speed),
    .measured_speed(measured_speed),
    .trk_valid     (trk_valid),
    .trk_ready     (trk_ready),
    .trk_err       (trk_err),
    .trk_sum       (trk_sum),
    .trk_flags     (trk_flags)
  );

  // pi products, offset and clamp
  rpsr_shape #(
    .SPEED_FRAC_BITS(SPEED_FRAC_BITS),
    .INTEG_WIDTH    (INTEG_WIDTH)
  ) u_shape (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .trk_valid  (trk_valid),
    .trk_ready  (trk_ready),
    .trk_err    (trk_err),
    .trk_sum    (trk_sum),
    .trk_flags  (trk_flags),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pulse_width(pulse_width),
    .stopped    (stopped)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ramped pi speed regulator testbench
// Drives control-period transactions into the regulator and checks every
// pulse width and stopped flag against a cycle-free model of the ramp,
// error sum and clamp, or against the result a pinned table row gives.
// A short table covers the stop case, inverted direction, crossed limits and
// drives the error sum up and then down with integral gain only. Random
// register settings and speed sequences with idling on both sides follow.
// ----------------------------------------------------------------------------
module testbench;
  import rpsr_pkg::*;

  localparam int SPEED_FRAC      = 8;
  localparam int ISUM_BITS       = 32;
  localparam int OUT_FRAC        = GAIN_FRAC_BITS + SPEED_FRAC;
  localparam longint ISUM_MAX    = (64'sd1 <<< (ISUM_BITS - 1)) - 1;
  localparam longint ISUM_MIN    = -ISUM_MAX - 1;
  localparam logic [2:0] REG_NONE = 3'd7;  // index past the last register
  localparam int SOAK_ITEMS      = 24;
  localparam int RAND_CHUNKS     = 7;
  localparam int CHUNK_ITEMS     = 100;
  localparam int HOLD_CHUNK      = 2;
  localparam int PAUSE_CHUNK     = 4;
  localparam int HOLD_CYCLES     = 60;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 1000000;

  typedef struct packed {
    logic [11:0] width_us;
    logic        halted;
  } pulse_t;

  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [15:0] data;
    logic [15:0] tgt;
    logic [14:0] meas;
    int          reps;
    logic        pinned;
    logic [11:0] width_us;
    logic        halted;
  } row_t;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] target_speed;
  logic        [14:0] measured_speed;
  logic               out_valid;
  logic               out_ready;
  logic        [11:0] pulse_width;
  logic               stopped;

  // result typed in by the table, travels with the payload
  logic               pin_en;
  logic        [11:0] pin_width;
  logic               pin_halted;

  // model state
  cfg_t   reg_shadow;
  longint ramp_shadow;
  longint isum_shadow;
  pulse_t expected_pulses[$];

  bit tx_idle_en;
  bit rx_idle_en;
  bit rx_hold_req;
  bit pending_since_cfg;

  int          mismatches;
  int          results_checked;
  int          items_sent;
  int          reg_writes;
  int unsigned cycle_count;

  ramped_pi_speed_regulator #(
    .SPEED_FRAC_BITS(SPEED_FRAC),
    .INTEG_WIDTH    (ISUM_BITS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .target_speed  (target_speed),
    .measured_speed(measured_speed),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pulse_width   (pulse_width),
    .stopped       (stopped)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one control period: ramp toward the target, pi sum, direction, clamp
  function automatic pulse_t regulate(logic signed [15:0] tgt, logic [14:0] meas);
    longint spd, mag, diff, step, err, sum, total, lo, hi;
    pulse_t res;
    spd = tgt;
    if (reg_shadow.invert_direction) spd = -spd;
    if (spd == 0) begin
      ramp_shadow  = 0;
      isum_shadow  = 0;
      res.width_us = reg_shadow.standstill_width;
      res.halted   = 1'b1;
    end else begin
      mag  = (spd < 0) ? -spd : spd;
      step = longint'(reg_shadow.accel_step);
      diff = mag - ramp_shadow;
      if (diff < -step) diff = -step;
      else if (diff > step) diff = step;
      ramp_shadow = ramp_shadow + diff;
      err = ramp_shadow - longint'(meas);
      // saturating error sum
      sum = isum_shadow + err;
      if (sum > ISUM_MAX) sum = ISUM_MAX;
      else if (sum < ISUM_MIN) sum = ISUM_MIN;
      isum_shadow = sum;
      total = longint'(reg_shadow.prop_gain) * err
            + longint'(reg_shadow.integ_gain) * isum_shadow;
      if (spd < 0) total = -total;
      total = total + (longint'(reg_shadow.standstill_width) << OUT_FRAC);
      lo = longint'(reg_shadow.backward_limit) << OUT_FRAC;
      hi = longint'(reg_shadow.forward_limit) << OUT_FRAC;
      if (total < lo) total = lo;
      else if (total > hi) total = hi;
      res.width_us = 12'(total >>> OUT_FRAC);
      res.halted   = 1'b0;
    end
    return res;
  endfunction

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch: %s", msg);
  endtask

  // register writes, item predictions and result checks at each edge
  always @(posedge clk) begin : monitor
    pulse_t pred;
    pulse_t want;
    if (rst) begin
      reg_shadow.prop_gain        = PROP_GAIN_RST;
      reg_shadow.integ_gain       = INTEG_GAIN_RST;
      reg_shadow.accel_step       = ACCEL_STEP_RST;
      reg_shadow.standstill_width = STANDSTILL_WIDTH_RST;
      reg_shadow.forward_limit    = FORWARD_LIMIT_RST;
      reg_shadow.backward_limit   = BACKWARD_LIMIT_RST;
      reg_shadow.invert_direction = 1'b0;
      ramp_shadow = 0;
      isum_shadow = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          REG_PROP_GAIN:        reg_shadow.prop_gain        = cfg_data;
          REG_INTEG_GAIN:       reg_shadow.integ_gain       = cfg_data;
          REG_ACCEL_STEP:       reg_shadow.accel_step       = cfg_data[14:0];
          REG_STANDSTILL_WIDTH: reg_shadow.standstill_width = cfg_data[11:0];
          REG_FORWARD_LIMIT:    reg_shadow.forward_limit    = cfg_data[11:0];
          REG_BACKWARD_LIMIT:   reg_shadow.backward_limit   = cfg_data[11:0];
          REG_INVERT_DIRECTION: reg_shadow.invert_direction = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pred = regulate(target_speed, measured_speed);
        if (pin_en) pred = {pin_width, pin_halted};
        expected_pulses.push_back(pred);
      end
      if (out_valid && out_ready) begin
        if (expected_pulses.size() == 0) begin
          report($sformatf("unexpected result width %0d stopped %0b", pulse_width, stopped));
        end else begin
          want = expected_pulses.pop_front();
          if (pulse_width !== want.width_us)
            report($sformatf("result %0d: pulse_width %0d, want %0d",
                             results_checked, pulse_width, want.width_us));
          if (stopped !== want.halted)
            report($sformatf("result %0d: stopped %0b, want %0b",
                             results_checked, stopped, want.halted));
          results_checked++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_pulses.size());
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : receiver
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = rx_idle_en ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // stop offering and let every outstanding result come back
  task automatic wait_idle();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (expected_pulses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    pending_since_cfg = 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    if (pending_since_cfg) wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  task automatic send_item(logic signed [15:0] tgt, logic [14:0] meas,
                           logic pin, logic [11:0] width_us, logic halted);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 6) : 0;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    target_speed   <= tgt;
    measured_speed <= meas;
    pin_en         <= pin;
    pin_width      <= width_us;
    pin_halted     <= halted;
    do @(posedge clk); while (!(in_valid && in_ready));
    pending_since_cfg = 1'b1;
    items_sent++;
  endtask

  function automatic row_t reg_row(logic [2:0] idx, logic [15:0] data);
    row_t r;
    r      = '0;
    r.kind = ROW_REG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic row_t item_row(logic [15:0] tgt, logic [14:0] meas, int reps);
    row_t r;
    r      = '0;
    r.kind = ROW_ITEM;
    r.tgt  = tgt;
    r.meas = meas;
    r.reps = reps;
    return r;
  endfunction

  function automatic row_t pinned_row(logic [15:0] tgt, logic [14:0] meas,
                                      logic [11:0] width_us, logic halted);
    row_t r;
    r          = item_row(tgt, meas, 1);
    r.pinned   = 1'b1;
    r.width_us = width_us;
    r.halted   = halted;
    return r;
  endfunction

  // register value biased toward the extremes
  function automatic int pick(int hi);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  initial begin : stimulus
    row_t               dir_rows[$];
    int                 c, n, k, run, sel, mag;
    logic signed [15:0] tgt;
    logic        [14:0] meas;
    longint             m;

    rst            <= 1'b1;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    target_speed   <= '0;
    measured_speed <= '0;
    pin_en         <= 1'b0;
    pin_width      <= '0;
    pin_halted     <= 1'b0;
    tx_idle_en        = 1'b1;
    rx_idle_en        = 1'b1;
    rx_hold_req       = 1'b0;
    pending_since_cfg = 1'b0;

    // defaults after reset: stop, extremes of both fields
    dir_rows.push_back(pinned_row(16'sd0, 15'd0, 12'd1500, 1'b1));
    dir_rows.push_back(item_row(16'sh7fff, 15'd0, 1));
    dir_rows.push_back(item_row(16'sh7fff, 15'h7fff, 1));
    dir_rows.push_back(item_row(16'sh8000, 15'd0, 1));
    dir_rows.push_back(item_row(16'sd1, 15'd0, 1));
    dir_rows.push_back(item_row(-16'sd1, 15'h7fff, 1));
    dir_rows.push_back(pinned_row(16'sd0, 15'h7fff, 12'd1500, 1'b1));
    // full gains and step, widest limits: results pin to a limit
    dir_rows.push_back(reg_row(REG_PROP_GAIN, 16'hffff));
    dir_rows.push_back(reg_row(REG_INTEG_GAIN, 16'hffff));
    dir_rows.push_back(reg_row(REG_ACCEL_STEP, 16'h7fff));
    dir_rows.push_back(reg_row(REG_FORWARD_LIMIT, 16'd4095));
    dir_rows.push_back(reg_row(REG_BACKWARD_LIMIT, 16'd0));
    dir_rows.push_back(pinned_row(16'sh7fff, 15'd0, 12'd4095, 1'b0));
    dir_rows.push_back(pinned_row(16'sh8000, 15'd0, 12'd0, 1'b0));
    // inverted direction, most negative target turns into +32768
    dir_rows.push_back(reg_row(REG_INVERT_DIRECTION, 16'd1));
    dir_rows.push_back(pinned_row(16'sh8000, 15'd0, 12'd4095, 1'b0));
    dir_rows.push_back(pinned_row(16'sh7fff, 15'd0, 12'd0, 1'b0));
    dir_rows.push_back(pinned_row(16'sd0, 15'd100, 12'd1500, 1'b1));
    // zero gains, then zero step holds the ramp
    dir_rows.push_back(reg_row(REG_INVERT_DIRECTION, 16'd0));
    dir_rows.push_back(reg_row(REG_PROP_GAIN, 16'd0));
    dir_rows.push_back(reg_row(REG_INTEG_GAIN, 16'd0));
    dir_rows.push_back(item_row(16'sd12345, 15'd777, 1));
    dir_rows.push_back(reg_row(REG_ACCEL_STEP, 16'd0));
    dir_rows.push_back(item_row(16'sd20000, 15'd0, 1));
    // crossed limits; standstill written with the upper bits set
    dir_rows.push_back(reg_row(REG_STANDSTILL_WIDTH, 16'hffff));
    dir_rows.push_back(reg_row(REG_FORWARD_LIMIT, 16'd1000));
    dir_rows.push_back(reg_row(REG_BACKWARD_LIMIT, 16'd3000));
    dir_rows.push_back(pinned_row(16'sd0, 15'd0, 12'd4095, 1'b1));
    dir_rows.push_back(pinned_row(16'sd5, 15'd0, 12'd1000, 1'b0));
    dir_rows.push_back(reg_row(REG_STANDSTILL_WIDTH, 16'd0));
    dir_rows.push_back(reg_row(REG_PROP_GAIN, 16'hffff));
    dir_rows.push_back(reg_row(REG_ACCEL_STEP, 16'h7fff));
    dir_rows.push_back(pinned_row(16'sh8000, 15'd0, 12'd3000, 1'b0));
    dir_rows.push_back(pinned_row(16'sh7fff, 15'd0, 12'd1000, 1'b0));
    // write to an index past the register file is dropped
    dir_rows.push_back(reg_row(REG_NONE, 16'hffff));
    dir_rows.push_back(pinned_row(16'sd0, 15'd0, 12'd0, 1'b1));
    // integral only: runs push the error sum up and then down
    dir_rows.push_back(reg_row(REG_PROP_GAIN, 16'd0));
    dir_rows.push_back(reg_row(REG_INTEG_GAIN, 16'd1));
    dir_rows.push_back(reg_row(REG_STANDSTILL_WIDTH, 16'd2048));
    dir_rows.push_back(reg_row(REG_FORWARD_LIMIT, 16'd4095));
    dir_rows.push_back(reg_row(REG_BACKWARD_LIMIT, 16'd0));
    dir_rows.push_back(item_row(16'sh7fff, 15'd0, SOAK_ITEMS));
    dir_rows.push_back(pinned_row(16'sd0, 15'd0, 12'd2048, 1'b1));
    dir_rows.push_back(item_row(16'sd1, 15'h7fff, SOAK_ITEMS));
    dir_rows.push_back(item_row(16'sh7fff, 15'd0, 3));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_REG) begin
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        tx_idle_en = (dir_rows[r].reps == 1);
        rx_idle_en = tx_idle_en;
        repeat (dir_rows[r].reps)
          send_item(dir_rows[r].tgt, dir_rows[r].meas, dir_rows[r].pinned,
                    dir_rows[r].width_us, dir_rows[r].halted);
      end
    end

    // random register settings, each followed by a burst of speed sequences
    for (c = 0; c < RAND_CHUNKS; c++) begin
      if ($urandom_range(0, 3) == 0) write_reg(REG_PROP_GAIN, 16'(pick(65535)));
      else write_reg(REG_PROP_GAIN, 16'($urandom_range(0, 1023)));
      if ($urandom_range(0, 3) == 0) write_reg(REG_INTEG_GAIN, 16'(pick(65535)));
      else write_reg(REG_INTEG_GAIN, 16'($urandom_range(0, 63)));
      if ($urandom_range(0, 1) == 0)
        write_reg(REG_ACCEL_STEP, {1'($urandom), 15'(pick(32767))});
      else
        write_reg(REG_ACCEL_STEP, {1'($urandom), 15'($urandom_range(1, 2000))});
      write_reg(REG_STANDSTILL_WIDTH, {4'($urandom), 12'(pick(4095))});
      write_reg(REG_FORWARD_LIMIT, {4'($urandom), 12'(pick(4095))});
      write_reg(REG_BACKWARD_LIMIT, {4'($urandom), 12'(pick(4095))});
      write_reg(REG_INVERT_DIRECTION, {15'($urandom), 1'($urandom)});
      write_reg(REG_NONE, 16'($urandom));

      tx_idle_en = (c % 3) != 0;
      rx_idle_en = (c % 4) != 1;
      // long receiver hold-off while the sender keeps offering
      if (c == HOLD_CHUNK) begin
        tx_idle_en  = 1'b0;
        rx_hold_req = 1'b1;
      end

      n = 0;
      while (n < CHUNK_ITEMS) begin
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
          tgt = 16'sd0;
        end else if (sel == 1) begin
          case ($urandom_range(0, 3))
            0:       tgt = 16'sh8000;
            1:       tgt = 16'sh7fff;
            2:       tgt = 16'sd1;
            default: tgt = -16'sd1;
          endcase
        end else if (sel < 6) begin
          tgt = 16'($urandom);
        end else begin
          mag = $urandom_range(1, 6000);
          tgt = ($urandom_range(0, 1) == 1) ? 16'(-mag) : 16'(mag);
        end
        run = (sel == 0) ? 1 : $urandom_range(1, 12);
        // hold the target while the measured speed tracks the ramp
        for (k = 0; k < run && n < CHUNK_ITEMS; k++) begin
          if ($urandom_range(0, 3) == 0) begin
            meas = 15'($urandom);
          end else begin
            m = ramp_shadow + longint'($urandom_range(0, 1024)) - 512;
            if (m < 0) m = 0;
            else if (m > 32767) m = 32767;
            meas = 15'(m);
          end
          send_item(tgt, meas, 1'b0, 12'd0, 1'b0);
          n++;
          // sender pauses until the pipeline has drained
          if (c == PAUSE_CHUNK && n == CHUNK_ITEMS / 2) wait_idle();
        end
      end
    end

    wait_idle();
    $display("%0d transactions in, %0d results checked, %0d register writes",
             items_sent, results_checked, reg_writes);
    $display("covered stop, ramp limits, inversion, crossed limits, integral runs");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
